[rtl/wqarc_pkg.sv]
// Shared types and constants for the water quality alarm and relay controller.
package wqarc_pkg;

  localparam int unsigned CODE_W = 12;
  localparam int unsigned HOLD_W = 24;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned NUM_RELAYS = 4;

  // Highest valid water temperature, 60 degC in 1/16 degC steps.
  localparam logic signed [CODE_W-1:0] TEMP_VALID_MAX = 12'sd960;

  localparam int unsigned RELAY_PUMP = 0;
  localparam int unsigned RELAY_AERATOR = 1;
  localparam int unsigned RELAY_CIRC = 2;
  localparam int unsigned RELAY_FEEDER = 3;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_MANUAL = 2'd2,
    CMD_MODE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_TEMP_LIMITS   = 3'd0,
    REG_PH_LIMITS     = 3'd1,
    REG_OXYGEN_LIMITS = 3'd2,
    REG_CO2_TURB      = 3'd3,
    REG_PUMP_HOLD     = 3'd4,
    REG_VALVE_HOLD    = 3'd5,
    REG_FEEDER_HOLD   = 3'd6,
    REG_RELAYS_LOCKED = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [47:0]       temp_limits;
    logic [23:0]       ph_limits;
    logic [35:0]       oxygen_limits;
    logic [23:0]       co2_turbidity_limits;
    logic [HOLD_W-1:0] pump_hold_ms;
    logic [HOLD_W-1:0] valve_hold_ms;
    logic [HOLD_W-1:0] feeder_hold_ms;
    logic              relays_locked;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] temp_code;
    logic [CODE_W-1:0] ph_code;
    logic [CODE_W-1:0] oxygen_code;
    logic [CODE_W-1:0] co2_code;
    logic [CODE_W-1:0] turbidity_code;
    logic [1:0]        relay_index;
    logic              relay_request;
    logic              auto_request;
  } item_t;

  // Stored condition flags, lowest bit is temp high.
  typedef struct packed {
    logic crit;
    logic any;
    logic fault;
    logic turb_high;
    logic co2_over;
    logic oxy_crit;
    logic oxy_low;
    logic ph_out;
    logic temp_crit_high;
    logic temp_crit_low;
    logic temp_under;
    logic temp_over;
  } flags_t;

  typedef struct packed {
    logic                  auto_active;
    logic                  command_suppressed;
    logic                  critical_active;
    logic                  any_alarm;
    logic                  sensor_fault;
    logic [8:0]            condition_flags;
    logic [NUM_RELAYS-1:0] relay_states;
  } result_t;

endpackage

[rtl/wqarc_eval.sv]
// Sample validity checks and threshold comparisons.
module wqarc_eval
  import wqarc_pkg::*;
(
  input  item_t  item,
  input  cfg_t   cfg,
  output flags_t flags
);

  logic signed [CODE_W-1:0] t;
  logic signed [CODE_W-1:0] t_min;
  logic signed [CODE_W-1:0] t_max;
  logic signed [CODE_W-1:0] t_crit_low;
  logic signed [CODE_W-1:0] t_crit_high;
  logic tv;
  logic pv;
  logic ov;

  assign t           = item.temp_code;
  assign t_min       = cfg.temp_limits[11:0];
  assign t_max       = cfg.temp_limits[23:12];
  assign t_crit_low  = cfg.temp_limits[35:24];
  assign t_crit_high = cfg.temp_limits[47:36];

  assign tv = (t > 12'sd0) && (t <= TEMP_VALID_MAX);
  assign pv = (item.ph_code != '0);
  assign ov = (item.oxygen_code != '0);

  always_comb begin
    flags.temp_over      = tv && (t > t_max);
    flags.temp_under     = tv && (t < t_min);
    flags.temp_crit_low  = tv && (t <= t_crit_low);
    flags.temp_crit_high = tv && (t >= t_crit_high);
    flags.ph_out         = pv && ((item.ph_code < cfg.ph_limits[11:0]) ||
                                  (item.ph_code > cfg.ph_limits[23:12]));
    flags.oxy_low        = ov && (item.oxygen_code < cfg.oxygen_limits[11:0]);
    flags.oxy_crit       = ov && (item.oxygen_code <= cfg.oxygen_limits[23:12]);
    flags.co2_over       = item.co2_code > cfg.co2_turbidity_limits[11:0];
    flags.turb_high      = item.turbidity_code > cfg.co2_turbidity_limits[23:12];
    flags.fault          = !(tv && pv && ov);
    flags.any            = flags.temp_over || flags.temp_under || flags.ph_out ||
                           flags.oxy_low || flags.oxy_crit || flags.co2_over ||
                           flags.turb_high;
    flags.crit           = flags.oxy_crit || flags.temp_crit_low || flags.temp_crit_high;
  end

endmodule

[rtl/wqarc_ctrl.sv]
// Controller state: millisecond clock, relays, change times, mode and stored flags.
module wqarc_ctrl
  import wqarc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  input  flags_t  flags_new,
  output result_t result
);

  logic [TIME_W-1:0]     time_now_r;
  logic [TIME_W-1:0]     time_now_nxt;
  logic [TIME_W-1:0]     last_change_r   [NUM_RELAYS];
  logic [TIME_W-1:0]     last_change_nxt [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] relay_bits_r;
  logic [NUM_RELAYS-1:0] relay_bits_nxt;
  logic                  auto_mode_r;
  logic                  auto_mode_nxt;
  flags_t                flag_store_r;
  flags_t                flag_store_nxt;

  logic [NUM_RELAYS-1:0] rb0;
  logic [NUM_RELAYS-1:0] want;
  logic [NUM_RELAYS-1:0] hold_ok;
  logic [HOLD_W-1:0]     hold [NUM_RELAYS];
  logic [CODE_W:0]       circ_level;
  logic                  circ_low;
  logic                  suppressed;

  assign hold[RELAY_PUMP]    = cfg.pump_hold_ms;
  assign hold[RELAY_AERATOR] = cfg.valve_hold_ms;
  assign hold[RELAY_CIRC]    = cfg.valve_hold_ms;
  assign hold[RELAY_FEEDER]  = cfg.feeder_hold_ms;

  // Elapsed time is taken modulo 2^32, so the subtraction wraps on purpose.
  always_comb begin
    for (int i = 0; i < NUM_RELAYS; i++) begin
      hold_ok[i] = (time_now_r - last_change_r[i]) >
                   {{(TIME_W-HOLD_W){1'b0}}, hold[i]};
    end
  end

  assign rb0 = cfg.relays_locked ? '0 : relay_bits_r;

  assign circ_level = {1'b0, cfg.oxygen_limits[11:0]} + {1'b0, cfg.oxygen_limits[35:24]};
  assign circ_low   = (item.oxygen_code != '0) && ({1'b0, item.oxygen_code} < circ_level);

  always_comb begin
    want[RELAY_PUMP]    = rb0[RELAY_PUMP] | flags_new.oxy_crit | flags_new.temp_crit_high |
                          flags_new.co2_over;
    want[RELAY_AERATOR] = rb0[RELAY_AERATOR] | flags_new.oxy_crit | flags_new.oxy_low |
                          flags_new.co2_over;
    want[RELAY_CIRC]    = rb0[RELAY_CIRC] | flags_new.temp_crit_high | flags_new.temp_over |
                          circ_low;
    want[RELAY_FEEDER]  = 1'b0;
  end

  always_comb begin
    time_now_nxt   = time_now_r;
    relay_bits_nxt = rb0;
    auto_mode_nxt  = auto_mode_r;
    flag_store_nxt = flag_store_r;
    suppressed     = 1'b0;
    for (int i = 0; i < NUM_RELAYS; i++) begin
      last_change_nxt[i] = last_change_r[i];
    end
    case (item.cmd)
      CMD_TICK: begin
        time_now_nxt = time_now_r + 1'b1;
      end
      CMD_SAMPLE: begin
        flag_store_nxt = flags_new;
        if (!cfg.relays_locked && auto_mode_r) begin
          for (int i = 0; i < NUM_RELAYS; i++) begin
            if ((want[i] != rb0[i]) && hold_ok[i]) begin
              relay_bits_nxt[i]  = want[i];
              last_change_nxt[i] = time_now_r;
            end
          end
        end
      end
      CMD_MANUAL: begin
        auto_mode_nxt = 1'b0;
        suppressed    = item.relay_request && cfg.relays_locked;
        relay_bits_nxt[item.relay_index] = item.relay_request && !cfg.relays_locked;
      end
      CMD_MODE: begin
        auto_mode_nxt = item.auto_request;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r   <= '0;
      relay_bits_r <= '0;
      auto_mode_r  <= 1'b0;
      flag_store_r <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        last_change_r[i] <= '0;
      end
    end else if (step_en) begin
      time_now_r   <= time_now_nxt;
      relay_bits_r <= relay_bits_nxt;
      auto_mode_r  <= auto_mode_nxt;
      flag_store_r <= flag_store_nxt;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        last_change_r[i] <= last_change_nxt[i];
      end
    end
  end

  always_comb begin
    result.relay_states       = relay_bits_nxt;
    result.condition_flags    = flag_store_nxt[8:0];
    result.sensor_fault       = flag_store_nxt.fault;
    result.any_alarm          = flag_store_nxt.any;
    result.critical_active    = flag_store_nxt.crit;
    result.command_suppressed = suppressed;
    result.auto_active        = auto_mode_nxt;
  end

endmodule

[rtl/water_quality_alarm_relay_control.sv]
// Top level of the water quality alarm and relay controller.
//
//   Channel  Direction  Ports                                 Contents
//   in_      slave      in_tvalid/in_tready/in_tdata/in_tuser  tick, sample, manual, mode
//   out_     master     out_tvalid/out_tready/out_tdata        relays, flags, mode
//   cfg_     slave      cfg_valid/cfg_ready/cfg_index/cfg_data register writes
//
// One word is taken per cycle unless the output stalls; it lands in the input register
// at the accepting edge, and its result is loaded into the result register once that
// register is free, raising out_tvalid. Evaluation and the relay update are
// combinational between those registers. rst_n is synchronous; it clears the valid
// flags and the controller state and loads the default settings. When out_tready is
// low the result register holds and the input register fills, after which in_tready drops.
module water_quality_alarm_relay_control
  import wqarc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // temp[11:0], ph[23:12], oxygen[35:24], co2[47:36], turbidity[59:48],
  // relay_index[61:60], relay_request[62], auto_request[63]
  input  logic [63:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // relay_states[3:0], condition_flags[12:4], sensor_fault[13], any_alarm[14],
  // critical_active[15], command_suppressed[16], auto_active[17], zero[23:18]
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t    cfg_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_data_r;
  flags_t  flags_new;
  result_t result;
  logic    out_free;
  logic    advance;
  logic    in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_limits          <= '0;
      cfg_r.ph_limits            <= '0;
      cfg_r.oxygen_limits        <= '0;
      cfg_r.co2_turbidity_limits <= '0;
      cfg_r.pump_hold_ms         <= 24'd60000;
      cfg_r.valve_hold_ms        <= 24'd5000;
      cfg_r.feeder_hold_ms       <= 24'd60000;
      cfg_r.relays_locked        <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_TEMP_LIMITS:   cfg_r.temp_limits          <= cfg_data;
        REG_PH_LIMITS:     cfg_r.ph_limits            <= cfg_data[23:0];
        REG_OXYGEN_LIMITS: cfg_r.oxygen_limits        <= cfg_data[35:0];
        REG_CO2_TURB:      cfg_r.co2_turbidity_limits <= cfg_data[23:0];
        REG_PUMP_HOLD:     cfg_r.pump_hold_ms         <= cfg_data[HOLD_W-1:0];
        REG_VALVE_HOLD:    cfg_r.valve_hold_ms        <= cfg_data[HOLD_W-1:0];
        REG_FEEDER_HOLD:   cfg_r.feeder_hold_ms       <= cfg_data[HOLD_W-1:0];
        REG_RELAYS_LOCKED: cfg_r.relays_locked        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.cmd            <= cmd_t'(in_tuser);
      s1_item_r.temp_code      <= in_tdata[11:0];
      s1_item_r.ph_code        <= in_tdata[23:12];
      s1_item_r.oxygen_code    <= in_tdata[35:24];
      s1_item_r.co2_code       <= in_tdata[47:36];
      s1_item_r.turbidity_code <= in_tdata[59:48];
      s1_item_r.relay_index    <= in_tdata[61:60];
      s1_item_r.relay_request  <= in_tdata[62];
      s1_item_r.auto_request   <= in_tdata[63];
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  wqarc_eval u_eval (
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .flags (flags_new)
  );

  wqarc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .flags_new (flags_new),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the water quality alarm and relay controller.
module tb_top;
  import wqarc_pkg::*;

  localparam int SET_NORMAL = 0;
  localparam int SET_ZERO   = 1;
  localparam int SET_ONES   = 2;
  localparam int SET_LOCKED = 3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  water_quality_alarm_relay_control dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies kept alongside the block.
  logic [47:0] lim_temp;
  logic [23:0] lim_ph;
  logic [35:0] lim_oxygen;
  logic [23:0] lim_co2_turb;
  logic [23:0] hold_pump;
  logic [23:0] hold_valve;
  logic [23:0] hold_feeder;
  logic        locked;

  // Controller state as the block should hold it.
  logic [31:0]           now_ms;
  logic [31:0]           changed_at [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] relay_bits;
  logic                  auto_on;
  flags_t                stored_flags;

  result_t status_queue[$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned word_count [4];
  int unsigned rule_switches;
  int unsigned suppressed_count;
  int unsigned input_stalls;
  int unsigned settings_applied;

  int unsigned rx_mode;
  int unsigned rx_phase;
  int unsigned hold_req;
  int unsigned hold_left;
  bit          tx_bursty;
  int unsigned burst_left;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d, %s: got %0h, expected %0h",
             results_checked, field, got, want);
    errors++;
  endtask

  task automatic hold_switch(input int unsigned idx, input logic want,
                             input logic [23:0] hold);
    if (want != relay_bits[idx] && (now_ms - changed_at[idx]) > {8'd0, hold}) begin
      relay_bits[idx] = want;
      changed_at[idx] = now_ms;
      rule_switches++;
    end
  endtask

  // Advances the controller copy by one word and queues the status it returns.
  task automatic predict_status(input item_t it);
    result_t            r;
    logic signed [11:0] t;
    logic               tv, pv, ov, req;
    logic               want_pump, want_aer, want_circ;
    logic [12:0]        circ_level;
    r = '0;
    if (locked) relay_bits = '0;
    case (it.cmd)
      CMD_TICK: now_ms = now_ms + 32'd1;
      CMD_SAMPLE: begin
        t  = it.temp_code;
        tv = (t > 0) && (t <= TEMP_VALID_MAX);
        pv = it.ph_code != 12'd0;
        ov = it.oxygen_code != 12'd0;
        stored_flags.temp_over      = tv && (t > $signed(lim_temp[23:12]));
        stored_flags.temp_under     = tv && (t < $signed(lim_temp[11:0]));
        stored_flags.temp_crit_low  = tv && (t <= $signed(lim_temp[35:24]));
        stored_flags.temp_crit_high = tv && (t >= $signed(lim_temp[47:36]));
        stored_flags.ph_out = pv && (it.ph_code < lim_ph[11:0] ||
                                     it.ph_code > lim_ph[23:12]);
        stored_flags.oxy_low   = ov && (it.oxygen_code < lim_oxygen[11:0]);
        stored_flags.oxy_crit  = ov && (it.oxygen_code <= lim_oxygen[23:12]);
        stored_flags.co2_over  = it.co2_code > lim_co2_turb[11:0];
        stored_flags.turb_high = it.turbidity_code > lim_co2_turb[23:12];
        stored_flags.fault     = !(tv && pv && ov);
        stored_flags.any = stored_flags.temp_over || stored_flags.temp_under ||
                           stored_flags.ph_out || stored_flags.oxy_low ||
                           stored_flags.oxy_crit || stored_flags.co2_over ||
                           stored_flags.turb_high;
        stored_flags.crit = stored_flags.oxy_crit || stored_flags.temp_crit_low ||
                            stored_flags.temp_crit_high;
        if (!locked && auto_on) begin
          want_pump = relay_bits[RELAY_PUMP];
          want_aer  = relay_bits[RELAY_AERATOR];
          want_circ = relay_bits[RELAY_CIRC];
          if (stored_flags.oxy_crit) begin
            want_aer  = 1'b1;
            want_pump = 1'b1;
          end
          if (stored_flags.temp_crit_high) begin
            want_circ = 1'b1;
            want_pump = 1'b1;
          end
          if (stored_flags.oxy_low) want_aer = 1'b1;
          if (stored_flags.temp_over) want_circ = 1'b1;
          if (stored_flags.co2_over) begin
            want_pump = 1'b1;
            want_aer  = 1'b1;
          end
          // Minimum plus margin is a 13-bit sum, so it never wraps.
          circ_level = {1'b0, lim_oxygen[11:0]} + {1'b0, lim_oxygen[35:24]};
          if (ov && {1'b0, it.oxygen_code} < circ_level) want_circ = 1'b1;
          hold_switch(RELAY_PUMP, want_pump, hold_pump);
          hold_switch(RELAY_AERATOR, want_aer, hold_valve);
          hold_switch(RELAY_CIRC, want_circ, hold_valve);
          hold_switch(RELAY_FEEDER, 1'b0, hold_feeder);
        end
      end
      CMD_MANUAL: begin
        auto_on = 1'b0;
        req = it.relay_request;
        if (req && locked) begin
          r.command_suppressed = 1'b1;
          suppressed_count++;
          req = 1'b0;
        end
        relay_bits[it.relay_index] = req;
      end
      default: auto_on = it.auto_request;
    endcase
    r.relay_states    = relay_bits;
    r.condition_flags = stored_flags[8:0];
    r.sensor_fault    = stored_flags.fault;
    r.any_alarm       = stored_flags.any;
    r.critical_active = stored_flags.crit;
    r.auto_active     = auto_on;
    word_count[it.cmd]++;
    status_queue.push_back(r);
  endtask

  // Offers one word, waits for it to be taken, then, if the sender is bursty, idles at the end of each burst.
  task automatic send_item(input item_t it);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {it.auto_request, it.relay_request, it.relay_index, it.turbidity_code,
                  it.co2_code, it.oxygen_code, it.ph_code, it.temp_code};
    @(posedge clk);
    while (!in_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    predict_status(it);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEMP_LIMITS:   lim_temp     = value;
      REG_PH_LIMITS:     lim_ph       = value[23:0];
      REG_OXYGEN_LIMITS: lim_oxygen   = value[35:0];
      REG_CO2_TURB:      lim_co2_turb = value[23:0];
      REG_PUMP_HOLD:     hold_pump    = value[23:0];
      REG_VALVE_HOLD:    hold_valve   = value[23:0];
      REG_FEEDER_HOLD:   hold_feeder  = value[23:0];
      default:           locked       = value[0];
    endcase
    @(posedge clk);
  endtask

  // Random bits above the register width, which the block must ignore.
  function automatic logic [47:0] pad_junk(input logic [47:0] v, input int unsigned w);
    logic [47:0] mask;
    logic [47:0] junk;
    mask = (48'd1 << w) - 48'd1;
    junk = 48'({$urandom, $urandom});
    return (junk & ~mask) | (v & mask);
  endfunction

  task automatic apply_setting(input logic [47:0] t, input logic [23:0] ph,
                               input logic [35:0] ox, input logic [23:0] ct,
                               input logic [23:0] hp, input logic [23:0] hv,
                               input logic [23:0] hf, input logic lk);
    wait_drained();
    write_reg(REG_TEMP_LIMITS, t);
    write_reg(REG_PH_LIMITS, pad_junk(48'(ph), 24));
    write_reg(REG_OXYGEN_LIMITS, pad_junk(48'(ox), 36));
    write_reg(REG_CO2_TURB, pad_junk(48'(ct), 24));
    write_reg(REG_PUMP_HOLD, pad_junk(48'(hp), 24));
    write_reg(REG_VALVE_HOLD, pad_junk(48'(hv), 24));
    write_reg(REG_FEEDER_HOLD, pad_junk(48'(hf), 24));
    write_reg(REG_RELAYS_LOCKED, pad_junk(48'(lk), 1));
    settings_applied++;
  endtask

  task automatic random_setting(input int kind);
    logic [11:0] tmin, tmax, tcl, tch, ph_lo, ph_hi, ox_min, ox_crit, ox_margin;
    logic [23:0] hp, hv, hf;
    tmin      = 12'($urandom_range(100, 500));
    tmax      = 12'($urandom_range(400, 900));
    tcl       = 12'($urandom_range(0, 300));
    tch       = 12'($urandom_range(600, 960));
    ph_lo     = 12'($urandom_range(0, 2000));
    ph_hi     = 12'($urandom_range(2000, 4095));
    ox_min    = 12'($urandom_range(500, 3000));
    ox_crit   = 12'($urandom_range(0, 1500));
    ox_margin = 12'($urandom_range(0, 1500));
    hp = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 20));
    hv = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 20));
    hf = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 20));
    case (kind)
      SET_ZERO: apply_setting('0, '0, '0, '0, '0, '0, '0, 1'b0);
      SET_ONES: apply_setting('1, '1, '1, '1, '1, '1, '1, 1'b0);
      default:
        apply_setting({tch, tcl, tmax, tmin}, {ph_hi, ph_lo}, {ox_margin, ox_crit, ox_min},
                      24'($urandom), hp, hv, hf, kind == SET_LOCKED);
    endcase
  endtask

  function automatic item_t sample_word(input logic [11:0] temp, input logic [11:0] ph,
                                        input logic [11:0] ox, input logic [11:0] co2,
                                        input logic [11:0] turb);
    item_t it;
    it = '0;
    it.cmd = CMD_SAMPLE;
    it.temp_code = temp;
    it.ph_code = ph;
    it.oxygen_code = ox;
    it.co2_code = co2;
    it.turbidity_code = turb;
    return it;
  endfunction

  function automatic item_t control_word(input cmd_t c, input logic [1:0] idx,
                                         input logic req, input logic ar);
    item_t it;
    it = '0;
    it.cmd = c;
    it.relay_index = idx;
    it.relay_request = req;
    it.auto_request = ar;
    return it;
  endfunction

  // Mostly ticks and samples, with enough mode words to keep automatic control on.
  function automatic item_t random_word();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) it.cmd = CMD_TICK;
    else if (pick < 80) it.cmd = CMD_SAMPLE;
    else if (pick < 90) it.cmd = CMD_MANUAL;
    else it.cmd = CMD_MODE;
    if ($urandom_range(99) < 80) it.temp_code = 12'($urandom_range(1, 960));
    else it.temp_code = 12'($urandom);
    it.ph_code        = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom);
    it.oxygen_code    = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom);
    it.co2_code       = 12'($urandom);
    it.turbidity_code = 12'($urandom);
    it.relay_index    = 2'($urandom);
    it.relay_request  = 1'($urandom);
    it.auto_request   = ($urandom_range(99) < 85);
    return it;
  endfunction

  // Receiver: a long hold-off when asked, otherwise the stall pattern of the phase.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(99) < 70);
        default: out_tready <= (rx_phase % 7) < 4;
      endcase
    end
  end

  always @(posedge clk) begin : check_status
    result_t     want;
    logic [23:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (status_queue.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(got), 32'd0);
      end else begin
        want = status_queue.pop_front();
        if (got[3:0] !== want.relay_states)
          report_mismatch("relay_states", 32'(got[3:0]), 32'(want.relay_states));
        if (got[12:4] !== want.condition_flags)
          report_mismatch("condition_flags", 32'(got[12:4]), 32'(want.condition_flags));
        if (got[13] !== want.sensor_fault)
          report_mismatch("sensor_fault", 32'(got[13]), 32'(want.sensor_fault));
        if (got[14] !== want.any_alarm)
          report_mismatch("any_alarm", 32'(got[14]), 32'(want.any_alarm));
        if (got[15] !== want.critical_active)
          report_mismatch("critical_active", 32'(got[15]), 32'(want.critical_active));
        if (got[16] !== want.command_suppressed)
          report_mismatch("command_suppressed", 32'(got[16]),
                          32'(want.command_suppressed));
        if (got[17] !== want.auto_active)
          report_mismatch("auto_active", 32'(got[17]), 32'(want.auto_active));
        if (got[23:18] !== 6'd0)
          report_mismatch("padding", 32'(got[23:18]), 32'd0);
      end
      results_checked++;
    end
  end

  // Locked after reset: manual ON is refused and samples leave the relays off.
  task automatic test_after_reset();
    send_item(control_word(CMD_TICK, 2'd0, 1'b0, 1'b0));
    send_item(control_word(CMD_MANUAL, 2'(RELAY_PUMP), 1'b1, 1'b0));
    send_item(control_word(CMD_MANUAL, 2'(RELAY_FEEDER), 1'b0, 1'b0));
    send_item(control_word(CMD_MODE, 2'd0, 1'b0, 1'b1));
    send_item(sample_word(12'd400, 12'd2000, 12'd2000, 12'd100, 12'd100));
  endtask

  // Validity edges and samples sitting exactly on each threshold.
  task automatic test_sensor_limits();
    apply_setting({12'd640, 12'd160, 12'd480, 12'd320}, {12'd3000, 12'd1000},
                  {12'd500, 12'd800, 12'd1500}, {12'd3000, 12'd2000}, 24'd0, 24'd0,
                  24'd0, 1'b0);
    send_item(sample_word(12'd0, 12'hfff, 12'hfff, 12'd0, 12'd0));
    send_item(sample_word(12'd1, 12'd0, 12'd1, 12'hfff, 12'hfff));
    send_item(sample_word(12'd960, 12'd1000, 12'd0, 12'd2000, 12'd3000));
    send_item(sample_word(12'd961, 12'd3000, 12'd1500, 12'd2001, 12'd3001));
    send_item(sample_word(12'h800, 12'd999, 12'd800, 12'd0, 12'd0));
    send_item(sample_word(12'h7ff, 12'd3001, 12'd801, 12'd0, 12'd0));
    send_item(sample_word(12'hfff, 12'd2000, 12'd1999, 12'd0, 12'd0));
    send_item(sample_word(12'd320, 12'd2000, 12'd2000, 12'd0, 12'd0));
    send_item(sample_word(12'd160, 12'd2000, 12'd2000, 12'd0, 12'd0));
    send_item(sample_word(12'd640, 12'd2000, 12'd2000, 12'd0, 12'd0));
    send_item(sample_word(12'd480, 12'd2000, 12'd2000, 12'd0, 12'd0));
  endtask

  // Manual commands leave automatic mode; automatic rules then clear the feeder.
  task automatic test_manual_and_auto();
    send_item(control_word(CMD_MANUAL, 2'(RELAY_FEEDER), 1'b1, 1'b0));
    send_item(control_word(CMD_MANUAL, 2'(RELAY_AERATOR), 1'b1, 1'b0));
    send_item(control_word(CMD_MODE, 2'd0, 1'b0, 1'b1));
    send_item(control_word(CMD_TICK, 2'd0, 1'b0, 1'b0));
    send_item(sample_word(12'd700, 12'd2000, 12'd700, 12'd2500, 12'd100));
    send_item(control_word(CMD_MODE, 2'd0, 1'b0, 1'b0));
    send_item(sample_word(12'd700, 12'd2000, 12'd700, 12'd2500, 12'd100));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      case (p)
        1: random_setting(SET_ZERO);
        3: random_setting(SET_ONES);
        5: random_setting(SET_LOCKED);
        default: random_setting(SET_NORMAL);
      endcase
      rx_mode = p % 3;
      tx_bursty = (p % 2) == 1;
      repeat (100) send_item(random_word());
    end
  endtask

  // The receiver holds off while words keep coming, so the input side must stall.
  task automatic test_backpressure();
    random_setting(SET_NORMAL);
    rx_mode = 0;
    tx_bursty = 1'b0;
    hold_req = 80;
    repeat (40) send_item(random_word());
    wait_drained();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    lim_temp = '0;
    lim_ph = '0;
    lim_oxygen = '0;
    lim_co2_turb = '0;
    hold_pump = 24'd60000;
    hold_valve = 24'd5000;
    hold_feeder = 24'd60000;
    locked = 1'b1;
    now_ms = '0;
    foreach (changed_at[i]) changed_at[i] = '0;
    relay_bits = '0;
    auto_on = 1'b0;
    stored_flags = '0;
    rx_mode = 0;
    tx_bursty = 1'b0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_sensor_limits();
    test_manual_and_auto();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d words (%0d ticks, %0d samples, %0d manual, %0d mode)",
             word_count[CMD_TICK] + word_count[CMD_SAMPLE] + word_count[CMD_MANUAL] +
             word_count[CMD_MODE], word_count[CMD_TICK], word_count[CMD_SAMPLE],
             word_count[CMD_MANUAL], word_count[CMD_MODE]);
    $display("over %0d settings; %0d rule switches, %0d ONs refused, %0d stall cycles.",
             settings_applied, rule_switches, suppressed_count, input_stalls);
    if (errors == 0 && status_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
